// ===== design/mbe_pkg.sv =====
package mbe_pkg;

	localparam int FRAC_BITS   = 28;
	localparam int COORD_WIDTH = 32;
	localparam int STEP_W      = 11;
	localparam int NUM_CELLS   = 2;

	// multiplier operand: magnitude below 2.0
	localparam int OP_W   = FRAC_BITS + 1;
	localparam int PROD_W = 2 * OP_W;
	localparam int RE_W   = PROD_W - FRAC_BITS + 1;
	localparam int IM_W   = PROD_W - FRAC_BITS + 2;
	localparam int MAG_W  = ((COORD_WIDTH > IM_W) ? COORD_WIDTH : IM_W) + 1;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [STEP_W-1:0] RESET_STEPS   = STEP_W'(256);
	localparam logic              REG_MAX_STEPS = 1'b0;

	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
	} coord_t;

	typedef struct packed {
		logic              valid;
		logic              done;
		logic              zr_n;
		logic [MAG_W-1:0]  zr_m;
		logic              zi_n;
		logic [MAG_W-1:0]  zi_m;
		logic [STEP_W-1:0] steps;
	} tok_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} st_t;

endpackage

// ===== design/mbe_cell.sv =====
module mbe_cell
	import mbe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  coord_t            c_re,
	input  coord_t            c_im,
	input  logic [STEP_W-1:0] max_steps,
	input  tok_t              tin,
	output tok_t              tout
);

	function automatic logic [MAG_W:0] sm_add(
		input logic             na,
		input logic [MAG_W-1:0] ma,
		input logic             nb,
		input logic [MAG_W-1:0] mb
	);
		logic [MAG_W-1:0] m;
		logic             n;
		if (na == nb) begin
			m = ma + mb;
			n = na;
		end else if (ma >= mb) begin
			m = ma - mb;
			n = na;
		end else begin
			m = mb - ma;
			n = nb;
		end
		if (m == '0)
			n = 1'b0;
		return {n, m};
	endfunction

	// stage 1: limit and range check, the three products
	logic [OP_W-1:0]   zr_op;
	logic [OP_W-1:0]   zi_op;
	logic              stop1;
	logic              vld_s1;
	logic              done_s1;
	logic              pn_s1;
	logic [PROD_W-1:0] a_s1;
	logic [PROD_W-1:0] b_s1;
	logic [PROD_W-1:0] p_s1;
	logic [STEP_W-1:0] steps_s1;

	assign zr_op = tin.zr_m[OP_W-1:0];
	assign zi_op = tin.zi_m[OP_W-1:0];
	assign stop1 = tin.done || (tin.steps >= max_steps) ||
		(|tin.zr_m[MAG_W-1:OP_W]) || (|tin.zi_m[MAG_W-1:OP_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= tin.valid;
	end

	always_ff @(posedge clk) begin
		done_s1  <= stop1;
		pn_s1    <= tin.zr_n ^ tin.zi_n;
		a_s1     <= {{OP_W{1'b0}}, zr_op} * {{OP_W{1'b0}}, zr_op};
		b_s1     <= {{OP_W{1'b0}}, zi_op} * {{OP_W{1'b0}}, zi_op};
		p_s1     <= {{OP_W{1'b0}}, zr_op} * {{OP_W{1'b0}}, zi_op};
		steps_s1 <= tin.steps;
	end

	// stage 2: escape test, floored real and imaginary terms
	logic [PROD_W:0]          sum;
	logic                     dn;
	logic [PROD_W-1:0]        d;
	logic [RE_W-1:0]          re;
	logic [IM_W-1:0]          im;
	logic                     vld_s2;
	logic                     done_s2;
	logic                     re_n_s2;
	logic [RE_W-1:0]          re_s2;
	logic                     im_n_s2;
	logic [IM_W-1:0]          im_s2;
	logic [STEP_W-1:0]        steps_s2;

	assign sum = {1'b0, a_s1} + {1'b0, b_s1};
	assign dn  = a_s1 < b_s1;
	assign d   = dn ? (b_s1 - a_s1) : (a_s1 - b_s1);
	assign re  = RE_W'(d[PROD_W-1:FRAC_BITS]) +
		RE_W'(dn && (|d[FRAC_BITS-1:0]));
	assign im  = IM_W'(p_s1[PROD_W-1:FRAC_BITS-1]) +
		IM_W'(pn_s1 && (|p_s1[FRAC_BITS-2:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		done_s2  <= done_s1 || sum[PROD_W];
		re_n_s2  <= dn && (re != '0);
		re_s2    <= re;
		im_n_s2  <= pn_s1 && (im != '0);
		im_s2    <= im;
		steps_s2 <= steps_s1;
	end

	// stage 3: add c, count the step
	logic [MAG_W:0]    zr_new;
	logic [MAG_W:0]    zi_new;
	logic              vld_s3;
	logic              done_s3;
	logic              zr_n_s3;
	logic [MAG_W-1:0]  zr_m_s3;
	logic              zi_n_s3;
	logic [MAG_W-1:0]  zi_m_s3;
	logic [STEP_W-1:0] steps_s3;

	assign zr_new = sm_add(re_n_s2, MAG_W'(re_s2), c_re.neg, c_re.mag);
	assign zi_new = sm_add(im_n_s2, MAG_W'(im_s2), c_im.neg, c_im.mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else
			vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		done_s3  <= done_s2;
		zr_n_s3  <= zr_new[MAG_W];
		zr_m_s3  <= zr_new[MAG_W-1:0];
		zi_n_s3  <= zi_new[MAG_W];
		zi_m_s3  <= zi_new[MAG_W-1:0];
		steps_s3 <= done_s2 ? steps_s2 : steps_s2 + STEP_W'(1);
	end

	assign tout = '{
		valid: vld_s3,
		done:  done_s3,
		zr_n:  zr_n_s3,
		zr_m:  zr_m_s3,
		zi_n:  zi_n_s3,
		zi_m:  zi_m_s3,
		steps: steps_s3
	};

endmodule

// ===== design/mandelbrot_escape_time.sv =====
// Mandelbrot escape-time counter, one point c at a time, Q4.28 coordinates.
// Input channel: c_real, c_imag with in_valid / in_stall. A word is taken
// when in_valid is high and in_stall is low. in_stall stays high from the
// cycle after a take until that point's count sits in the output register.
// Output channel: step_count with out_valid / out_stall; the count is held
// in a register until taken, and a new point may be taken meanwhile.
// Config: APB register 0 (byte address 0) is max_steps, 11 bits, reset 256.
// The iteration runs around a ring of NUM_CELLS identical cells; each cell
// does one z = z*z + c step in three pipeline stages (products, escape test
// and flooring, add of c). A finished point leaves the ring at the output of
// the last cell, where its count is taken into the output register.
// When the receiver stalls with a count still held, the finished point
// keeps circling the ring and is handed over on a later pass.
// Reset (arst_n low) empties the ring and output register and sets
// max_steps to 256.
module mandelbrot_escape_time
	import mbe_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] c_real,
	input  logic signed [COORD_WIDTH-1:0] c_imag,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [STEP_W-1:0]             step_count,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ADDR_W-1:0]             paddr,
	input  logic [DATA_W-1:0]             pwdata,
	output logic [DATA_W-1:0]             prdata,
	output logic                          pready
);

	st_t               state_q;
	st_t               state_nxt;
	coord_t            c_re_q;
	coord_t            c_im_q;
	logic [STEP_W-1:0] max_steps_q;
	logic              out_valid_q;
	logic [STEP_W-1:0] step_count_q;
	logic              inject;
	logic              take;
	logic              reg_sel;
	tok_t              link [NUM_CELLS+1];
	tok_t              ring_in;
	tok_t              fresh;
	logic [COORD_WIDTH-1:0] cr_abs;
	logic [COORD_WIDTH-1:0] ci_abs;

	// config port
	assign pready  = 1'b1;
	assign reg_sel = paddr[ADDR_W-1] == REG_MAX_STEPS;
	assign prdata  = reg_sel ? DATA_W'(max_steps_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_steps_q <= RESET_STEPS;
		else if (psel && penable && pwrite && pready && reg_sel)
			max_steps_q <= pwdata[STEP_W-1:0];
	end

	// control
	assign in_stall = state_q != ST_IDLE;
	assign inject   = (state_q == ST_IDLE) && in_valid;
	assign take     = link[NUM_CELLS].valid && link[NUM_CELLS].done &&
		(!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_nxt = ST_RUN;
			end
			ST_RUN: begin
				if (take)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// point register, sign and magnitude
	assign cr_abs = c_real[COORD_WIDTH-1] ? (~$unsigned(c_real) + COORD_WIDTH'(1))
		: $unsigned(c_real);
	assign ci_abs = c_imag[COORD_WIDTH-1] ? (~$unsigned(c_imag) + COORD_WIDTH'(1))
		: $unsigned(c_imag);

	always_ff @(posedge clk) begin
		if (inject) begin
			c_re_q.neg <= c_real[COORD_WIDTH-1];
			c_re_q.mag <= MAG_W'(cr_abs);
			c_im_q.neg <= c_imag[COORD_WIDTH-1];
			c_im_q.mag <= MAG_W'(ci_abs);
		end
	end

	// ring of cells
	assign fresh = '{
		valid: 1'b1,
		done:  1'b0,
		zr_n:  1'b0,
		zr_m:  '0,
		zi_n:  1'b0,
		zi_m:  '0,
		steps: '0
	};

	always_comb begin
		if (inject)
			ring_in = fresh;
		else if (link[NUM_CELLS].valid && !take)
			ring_in = link[NUM_CELLS];
		else begin
			ring_in = link[NUM_CELLS];
			ring_in.valid = 1'b0;
		end
	end

	assign link[0] = ring_in;

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		mbe_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.c_re      (c_re_q),
			.c_im      (c_im_q),
			.max_steps (max_steps_q),
			.tin       (link[i]),
			.tout      (link[i+1])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (take)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take)
			step_count_q <= link[NUM_CELLS].steps;
	end

	assign out_valid  = out_valid_q;
	assign step_count = step_count_q;

endmodule

// ===== design/mbe_checker.sv =====
module mbe_checker
	import mbe_pkg::*;
(
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [STEP_W-1:0]             step_count,
	input logic                          psel,
	input logic                          penable,
	input logic                          pwrite,
	input logic [ADDR_W-1:0]             paddr,
	input logic [DATA_W-1:0]             pwdata,
	input logic [DATA_W-1:0]             prdata,
	input logic                          pready
);

	logic wr_steps;
	logic rd_steps;

	assign wr_steps = psel && penable && pwrite && pready &&
		(paddr[ADDR_W-1] == REG_MAX_STEPS);
	assign rd_steps = psel && !pwrite && (paddr[ADDR_W-1] == REG_MAX_STEPS);

	// a held word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(step_count))
		else $error("output word changed while stalled");

	// one point at a time
	a_one_point: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a point is in flight");

	// the point is released only once its count is registered
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_stall) |-> out_valid)
		else $error("input reopened without a result");

	// readback of a just-written limit
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		$past(wr_steps) && rd_steps |->
			prdata[STEP_W-1:0] == $past(pwdata[STEP_W-1:0]))
		else $error("max_steps readback mismatch");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (.*);
